[rtl/core/rpg_pkg.sv]
// Shared constants for the 3x3 stride-2 RGB patch gather.
// Store geometry, register indexes and reset values; no dependencies.
package rpg_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_HEIGHT  = 4096;
    localparam int MAX_PAD     = 64;
    localparam int STORE_ROWS  = 4;
    localparam int ROW_BITS    = $clog2(STORE_ROWS);
    localparam int BANK_DEPTH  = MAX_WIDTH / 2;
    localparam int BANK_AW     = $clog2(BANK_DEPTH);
    localparam int PIX_W       = 24;
    localparam int DIV_STEPS   = 13;
    localparam int DIV_CNT_W   = 4;

    localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_PAD_MULTIPLE = 2'd2;

    localparam logic [11:0] RST_FRAME_WIDTH  = 12'd320;
    localparam logic [12:0] RST_FRAME_HEIGHT = 13'd240;
    localparam logic [6:0]  RST_PAD_MULTIPLE = 7'd32;
    // Grid size for the reset registers: ceil(240/32)*16 and ceil(320/32)*16
    localparam logic [11:0] RST_GRID_ROWS    = 12'd128;
    localparam logic [10:0] RST_GRID_COLS    = 11'd160;

    typedef logic [PIX_W-1:0] pixel_t;

endpackage

[rtl/core/rgb_patch_gather_3x3_stride2_core.sv]
// Top level of the 3x3 stride-2 RGB patch gather (im2col with zero padding).
// Uses rpg_pkg for store geometry, register indexes and reset values.
//
// Usage:
//   Input channel (in_valid/in_ready): cmd=0 carries one RGB pixel in raster
//   order, cmd=1 is an idle tick that lets the padding patches drain.
//   Output channel (out_valid/out_ready): one 3x3 patch with its grid
//   position and frame_last on the last patch of the padded grid.
//   Configuration: cfg_we writes cfg_data into register cfg_index
//   (0 width, 1 height, 2 pad multiple); write only while the block is idle.
// Throughput: one item per cycle while in_ready is high. Pixels live in a line
//   store of four rows split into even/odd column banks per row, so all nine
//   taps of a patch are read together; a same-cycle write is forwarded.
// Path: a patch released by a transferred item passes the store read register
//   (read stage) and then the output register.
// Reset and register writes: the padded grid size is recomputed by a
//   one-bit-per-step divider; in_ready stays low until it is done, after reset
//   release and after every register write. The line store is not cleared.
// Stall: the output register holds while out_ready is low; one patch waits
//   in the read stage behind it, and while that patch cannot move in_ready
//   stays low for every item, whether or not it would release a patch.
module rgb_patch_gather_3x3_stride2_core
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [23:0] tap_nw,
    output logic [23:0] tap_n,
    output logic [23:0] tap_ne,
    output logic [23:0] tap_w,
    output logic [23:0] tap_c,
    output logic [23:0] tap_e,
    output logic [23:0] tap_sw,
    output logic [23:0] tap_s,
    output logic [23:0] tap_se,
    output logic [11:0] patch_row,
    output logic [10:0] patch_col,
    output logic        frame_last
);

    localparam int RB = rpg_pkg::ROW_BITS;
    localparam int AW = rpg_pkg::BANK_AW;

    // ---------------- configuration registers ----------------
    logic [11:0] frame_width_reg;
    logic [12:0] frame_height_reg;
    logic [6:0]  pad_multiple_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= rpg_pkg::RST_FRAME_WIDTH;
            frame_height_reg <= rpg_pkg::RST_FRAME_HEIGHT;
            pad_multiple_reg <= rpg_pkg::RST_PAD_MULTIPLE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rpg_pkg::CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[11:0];
                rpg_pkg::CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                rpg_pkg::CFG_PAD_MULTIPLE: pad_multiple_reg <= cfg_data[6:0];
                default:                   ;
            endcase
        end
    end

    logic [11:0] w_c;
    logic [12:0] h_c;
    logic [6:0]  p_c;

    always_comb
    begin
        if (frame_width_reg == 12'd0)
            w_c = 12'd1;
        else if (frame_width_reg > 12'(rpg_pkg::MAX_WIDTH))
            w_c = 12'(rpg_pkg::MAX_WIDTH);
        else
            w_c = frame_width_reg;
        if (frame_height_reg == 13'd0)
            h_c = 13'd1;
        else if (frame_height_reg > 13'(rpg_pkg::MAX_HEIGHT))
            h_c = 13'(rpg_pkg::MAX_HEIGHT);
        else
            h_c = frame_height_reg;
        if (pad_multiple_reg == 7'd0)
            p_c = 7'd1;
        else if (pad_multiple_reg > 7'(rpg_pkg::MAX_PAD))
            p_c = 7'(rpg_pkg::MAX_PAD);
        else
            p_c = pad_multiple_reg;
    end

    // ---------------- grid size: restoring divider ----------------
    // rows = ((h-1)/p + 1) * p / 2, cols likewise; both dividers share the count
    logic                          start_reg;
    logic                          busy_reg;
    logic [rpg_pkg::DIV_CNT_W-1:0] div_cnt_reg;
    logic [12:0]                   nh_reg, nw_reg;
    logic [12:0]                   qh_reg, qw_reg;
    logic [6:0]                    rh_reg, rw_reg;
    logic [11:0]                   rows_reg;
    logic [10:0]                   cols_reg;

    logic [7:0]  rh_try, rw_try;
    logic        h_bit, w_bit;
    logic [20:0] rows_prod, cols_prod;

    always_comb
    begin
        rh_try    = {rh_reg, nh_reg[12]};
        rw_try    = {rw_reg, nw_reg[12]};
        h_bit     = (rh_try >= {1'b0, p_c});
        w_bit     = (rw_try >= {1'b0, p_c});
        rows_prod = 21'({1'b0, qh_reg} + 14'd1) * 21'(p_c);
        cols_prod = 21'({1'b0, qw_reg} + 14'd1) * 21'(p_c);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg   <= 1'b1;
            busy_reg    <= 1'b0;
            div_cnt_reg <= '0;
            rows_reg    <= rpg_pkg::RST_GRID_ROWS;
            cols_reg    <= rpg_pkg::RST_GRID_COLS;
        end
        else if (cfg_we)
        begin
            start_reg <= 1'b1;
            busy_reg  <= 1'b0;
        end
        else if (start_reg)
        begin
            start_reg   <= 1'b0;
            busy_reg    <= 1'b1;
            div_cnt_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (div_cnt_reg == rpg_pkg::DIV_CNT_W'(rpg_pkg::DIV_STEPS))
            begin
                busy_reg <= 1'b0;
                rows_reg <= rows_prod[12:1];
                cols_reg <= cols_prod[11:1];
            end
            else
                div_cnt_reg <= div_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_reg)
        begin
            nh_reg <= h_c - 13'd1;
            nw_reg <= {1'b0, w_c - 12'd1};
            qh_reg <= '0;
            qw_reg <= '0;
            rh_reg <= '0;
            rw_reg <= '0;
        end
        else if (busy_reg && div_cnt_reg != rpg_pkg::DIV_CNT_W'(rpg_pkg::DIV_STEPS))
        begin
            nh_reg <= {nh_reg[11:0], 1'b0};
            nw_reg <= {nw_reg[11:0], 1'b0};
            qh_reg <= {qh_reg[11:0], h_bit};
            qw_reg <= {qw_reg[11:0], w_bit};
            rh_reg <= h_bit ? 7'(rh_try - {1'b0, p_c}) : rh_try[6:0];
            rw_reg <= w_bit ? 7'(rw_try - {1'b0, p_c}) : rw_try[6:0];
        end
    end

    // ---------------- position counters ----------------
    logic [12:0] in_row_reg,  in_row_next;
    logic [10:0] in_col_reg,  in_col_next;
    logic [11:0] out_row_reg, out_row_next;
    logic [10:0] out_col_reg, out_col_next;

    logic        s1_valid_reg;
    logic        out_valid_reg;
    logic        s1_adv;
    logic        acc;
    logic        wr_en;
    logic [11:0] ic_inc;
    logic [12:0] ir1;
    logic [10:0] ic1;
    logic [11:0] or0;
    logic [10:0] oc0;
    logic [12:0] yr_raw, yr;
    logic [11:0] xr_raw, xr;
    logic        rel;
    logic        emit;
    logic [10:0] oc_inc;
    logic [11:0] or2;
    logic [10:0] oc2;

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !start_reg && !busy_reg && (!s1_valid_reg || s1_adv);
    assign acc      = in_valid && in_ready;

    always_comb
    begin
        wr_en  = acc && !cmd && (in_row_reg < h_c);
        ic_inc = {1'b0, in_col_reg} + 12'd1;
        ir1    = in_row_reg;
        ic1    = in_col_reg;
        if (wr_en)
        begin
            if (ic_inc >= w_c)
            begin
                ic1 = '0;
                ir1 = in_row_reg + 13'd1;
            end
            else
                ic1 = ic_inc[10:0];
        end

        // wrap a column left past a narrower grid
        or0 = out_row_reg;
        oc0 = out_col_reg;
        if (out_row_reg < rows_reg && out_col_reg >= cols_reg)
        begin
            oc0 = '0;
            or0 = out_row_reg + 12'd1;
        end

        // last pixel the next patch needs
        yr_raw = {or0, 1'b1};
        xr_raw = {oc0, 1'b1};
        yr     = (yr_raw > h_c - 13'd1) ? h_c - 13'd1 : yr_raw;
        xr     = (xr_raw > w_c - 12'd1) ? w_c - 12'd1 : xr_raw;
        rel    = (ir1 >= h_c) || (ir1 > yr) || ((ir1 == yr) && ({1'b0, ic1} > xr));
        emit   = acc && (or0 < rows_reg) && (cols_reg != 11'd0) && rel;

        or2    = or0;
        oc2    = oc0;
        oc_inc = oc0 + 11'd1;
        if (emit)
        begin
            if (oc_inc >= cols_reg)
            begin
                oc2 = '0;
                or2 = or0 + 12'd1;
            end
            else
                oc2 = oc_inc;
        end

        in_row_next  = ir1;
        in_col_next  = ic1;
        out_row_next = or2;
        out_col_next = oc2;
        // frame done: start over
        if (ir1 >= h_c && (or2 >= rows_reg || cols_reg == 11'd0))
        begin
            in_row_next  = '0;
            in_col_next  = '0;
            out_row_next = '0;
            out_col_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
        end
        else if (acc)
        begin
            in_row_reg  <= in_row_next;
            in_col_reg  <= in_col_next;
            out_row_reg <= out_row_next;
            out_col_reg <= out_col_next;
        end
    end

    // ---------------- line store: per row, even and odd column banks ----------------
    rpg_pkg::pixel_t wr_data;
    logic [RB-1:0]   wr_row;
    logic [AW-1:0]   wr_idx;
    logic [AW-1:0]   ra_c, ra_l;
    logic [10:0]     oc0_m1;

    assign wr_data = {red, green, blue};
    assign wr_row  = in_row_reg[RB-1:0];
    assign wr_idx  = in_col_reg[AW:1];
    assign oc0_m1  = oc0 - 11'd1;
    assign ra_c    = oc0[AW-1:0];
    assign ra_l    = oc0_m1[AW-1:0];

    rpg_pkg::pixel_t mem_e [rpg_pkg::STORE_ROWS][rpg_pkg::BANK_DEPTH];
    rpg_pkg::pixel_t mem_o [rpg_pkg::STORE_ROWS][rpg_pkg::BANK_DEPTH];
    rpg_pkg::pixel_t rd_e  [rpg_pkg::STORE_ROWS];
    rpg_pkg::pixel_t rd_o0 [rpg_pkg::STORE_ROWS];
    rpg_pkg::pixel_t rd_o1 [rpg_pkg::STORE_ROWS];

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < rpg_pkg::STORE_ROWS; r++)
        begin
            if (wr_en && wr_row == RB'(r) && !in_col_reg[0])
                mem_e[r][wr_idx] <= wr_data;
            if (emit)
                rd_e[r] <= mem_e[r][ra_c];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < rpg_pkg::STORE_ROWS; r++)
        begin
            if (wr_en && wr_row == RB'(r) && in_col_reg[0])
                mem_o[r][wr_idx] <= wr_data;
            if (emit)
            begin
                rd_o0[r] <= mem_o[r][ra_l];
                rd_o1[r] <= mem_o[r][ra_c];
            end
        end
    end

    // ---------------- read stage ----------------
    logic [11:0]     s1_row_reg;
    logic [10:0]     s1_col_reg;
    logic            s1_last_reg;
    logic [RB-1:0]   s1_rsel_reg [3];
    logic [2:0]      s1_rv_reg, s1_cv_reg, s1_fwd_reg;
    logic [RB-1:0]   s1_wrow_reg;
    rpg_pkg::pixel_t s1_wdata_reg;

    logic [12:0]   cy;
    logic [11:0]   cx;
    logic [2:0]    rv, cv, fwd;
    logic [RB-1:0] rsel [3];

    always_comb
    begin
        cy    = {or0, 1'b0};
        cx    = {oc0, 1'b0};
        rv[0] = (or0 != 12'd0) && (cy - 13'd1 < h_c);
        rv[1] = (cy < h_c);
        rv[2] = (cy + 13'd1 < h_c);
        cv[0] = (oc0 != 11'd0) && (cx - 12'd1 < w_c);
        cv[1] = (cx < w_c);
        cv[2] = (cx + 12'd1 < w_c);
        for (int k = 0; k < 3; k++)
            rsel[k] = RB'(cy + 13'(k) - 13'd1);
        fwd[0] = wr_en && in_col_reg[0] && (wr_idx == ra_l);
        fwd[1] = wr_en && !in_col_reg[0] && (wr_idx == ra_c);
        fwd[2] = wr_en && in_col_reg[0] && (wr_idx == ra_c);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (emit)
            s1_valid_reg <= 1'b1;
        else if (s1_adv)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            s1_row_reg   <= or0;
            s1_col_reg   <= oc0;
            s1_last_reg  <= (or0 == rows_reg - 12'd1) && (oc0 == cols_reg - 11'd1);
            s1_rsel_reg  <= rsel;
            s1_rv_reg    <= rv;
            s1_cv_reg    <= cv;
            s1_fwd_reg   <= fwd;
            s1_wrow_reg  <= wr_row;
            s1_wdata_reg <= wr_data;
        end
    end

    rpg_pkg::pixel_t taps [9];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (j == 0)
                    taps[3*k+j] = rd_o0[s1_rsel_reg[k]];
                else if (j == 1)
                    taps[3*k+j] = rd_e[s1_rsel_reg[k]];
                else
                    taps[3*k+j] = rd_o1[s1_rsel_reg[k]];
                if (s1_fwd_reg[j] && s1_rsel_reg[k] == s1_wrow_reg)
                    taps[3*k+j] = s1_wdata_reg;
                if (!(s1_rv_reg[k] && s1_cv_reg[j]))
                    taps[3*k+j] = '0;
            end
        end
    end

    // ---------------- output register ----------------
    rpg_pkg::pixel_t tap_q_reg [9];
    logic [11:0]     row_q_reg;
    logic [10:0]     col_q_reg;
    logic            last_q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_adv)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            tap_q_reg  <= taps;
            row_q_reg  <= s1_row_reg;
            col_q_reg  <= s1_col_reg;
            last_q_reg <= s1_last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign tap_nw     = tap_q_reg[0];
    assign tap_n      = tap_q_reg[1];
    assign tap_ne     = tap_q_reg[2];
    assign tap_w      = tap_q_reg[3];
    assign tap_c      = tap_q_reg[4];
    assign tap_e      = tap_q_reg[5];
    assign tap_sw     = tap_q_reg[6];
    assign tap_s      = tap_q_reg[7];
    assign tap_se     = tap_q_reg[8];
    assign patch_row  = row_q_reg;
    assign patch_col  = col_q_reg;
    assign frame_last = last_q_reg;

    // ---------------- assertions ----------------
    a_emit_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (oc0 < cols_reg) && (or0 < rows_reg))
        else $error("patch issued outside the padded grid");

    a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_last |-> patch_row == rows_reg - 12'd1)
        else $error("frame_last away from the last grid row");

    a_read_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> s1_valid_reg && $stable(s1_col_reg))
        else $error("stalled read stage lost its patch");

    a_no_issue_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg || start_reg |-> !emit && !wr_en)
        else $error("item taken while grid size recomputes");

endmodule
